/* sv/gated_two_stage_pcm_resampler_unit_macros.svh */
// Assertion macros for the PCM resampler.
// Both forms assume a clock named clk and an active-low reset named arst_n in scope.
`ifndef GATED_TWO_STAGE_PCM_RESAMPLER_UNIT_MACROS_SVH
`define GATED_TWO_STAGE_PCM_RESAMPLER_UNIT_MACROS_SVH

`ifndef SYNTH
// Property that must hold at every clock edge outside reset
`define GTPR_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("resampler check failed");
// Property whose consequent must hold in the cycle after the antecedent
`define GTPR_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("resampler check failed");
`else
`define GTPR_ASSERT(lbl, prop)
`define GTPR_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

/* sv/gtpr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package gtpr_pkg;

	// Ring geometry
	localparam int RING_DEPTH = 2048;
	localparam int RING_AW    = $clog2(RING_DEPTH);

	// Publish increment and counter limits
	localparam int SAMPLES_PER_VBLANK = 224;
	localparam int CNT_W              = 40;
	localparam int POS_W              = 64;
	localparam int FRAC_BITS          = 24;
	localparam int STEP_W             = 32;

	// Field widths
	localparam int SLOT_W   = 11;
	localparam int SAMPLE_W = 8;
	localparam int PAIR_W   = 2 * SAMPLE_W;

	// Action codes
	localparam logic [1:0] ACT_WRITE   = 2'd0;
	localparam logic [1:0] ACT_PUBLISH = 2'd1;
	localparam logic [1:0] ACT_RENDER  = 2'd2;

	// Register indexes (paddr[2])
	localparam logic REG_SRC_STEP = 1'b0;
	localparam logic REG_DAC_STEP = 1'b1;

	// Ring access request: one write port, one read port
	typedef struct packed {
		logic               wr_en;
		logic [RING_AW-1:0] wr_addr;
		logic [PAIR_W-1:0]  wr_data;
		logic               rd_en;
		logic [RING_AW-1:0] rd_addr;
	} ring_req_t;

endpackage

`default_nettype wire

/* sv/gtpr_ring.sv */
`timescale 1ns / 1ps
`default_nettype none

module gtpr_ring
	import gtpr_pkg::*;
(
	input  wire logic              clk,
	input  wire ring_req_t         req,
	output logic [PAIR_W-1:0]      rd_data
);

	// Sample pair store: channel B in the upper byte
	logic [PAIR_W-1:0] mem [RING_DEPTH];

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
	end

	// Registered read, held while no new read is issued
	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			rd_data <= mem[req.rd_addr];
		end
	end

endmodule

`default_nettype wire

/* sv/gated_two_stage_pcm_resampler_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "gated_two_stage_pcm_resampler_unit_macros.svh"

// Channel   | Direction | Payload
// ----------+-----------+---------------------------------------------------
// s_axis    | in        | tdata: ring_slot, in_sample_a, in_sample_b; tuser: action
// m_axis    | out       | tdata: out_sample_a, out_sample_b; tuser: underrun
// apb       | in        | reg 0 source step at 0x0, reg 1 DAC step at 0x4
//
// One word per cycle is accepted while s_tready is high. A render word passes
// the registered ring read in the render stage, then the output register.
// Positions, published count and the ring are updated at acceptance; the
// held pairs are updated as a live render word moves into the output register.
// With m_tready low the output register and one render stage fill, then
// s_tready drops. Reset (arst_n) clears all control state; the ring is not cleared.

module gated_two_stage_pcm_resampler_unit
	import gtpr_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // [10:0] ring_slot, [18:11] in_sample_a, [26:19] in_sample_b
	input  wire logic [1:0]  s_tuser,   // [1:0] action
	// output stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,   // [7:0] out_sample_a, [15:8] out_sample_b
	output logic             m_tuser,   // [0] underrun
	// configuration
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	// Configuration registers
	logic [STEP_W-1:0] src_step_q;
	logic [STEP_W-1:0] dac_step_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_step_q <= '0;
			dac_step_q <= '0;
		end else if (psel && penable && pwrite && pready) begin
			unique case (paddr[2])
				REG_SRC_STEP: src_step_q <= pwdata;
				REG_DAC_STEP: dac_step_q <= pwdata;
				default:      ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_SRC_STEP: prdata = src_step_q;
			REG_DAC_STEP: prdata = dac_step_q;
			default:      prdata = '0;
		endcase
	end

	// Input word fields
	logic [1:0]          in_action;
	logic [SLOT_W-1:0]   in_slot;
	logic [SAMPLE_W-1:0] in_a;
	logic [SAMPLE_W-1:0] in_b;

	assign in_action = s_tuser;
	assign in_slot   = s_tdata[10:0];
	assign in_a      = s_tdata[18:11];
	assign in_b      = s_tdata[26:19];

	// Resampler state
	logic [POS_W-1:0] src_pos_q;
	logic [POS_W-1:0] dac_pos_q;
	logic [CNT_W-1:0] pub_cnt_q;
	logic [CNT_W-1:0] last_src_q;
	logic [CNT_W-1:0] last_dac_q;
	logic             src_vld_q;
	logic             dac_vld_q;

	// Render stage and output register
	logic              vld_s1;
	logic              silent_s1;
	logic              load_s1;
	logic              snap_s1;
	logic              underrun_s1;
	logic [PAIR_W-1:0] held_src_q;
	logic [PAIR_W-1:0] held_dac_q;
	logic              out_vld_q;
	logic [PAIR_W-1:0] out_data_q;
	logic              out_under_q;

	logic advance;
	logic in_acc;

	assign advance  = vld_s1 && (!out_vld_q || m_tready);
	assign s_tready = !vld_s1 || advance;
	assign in_acc   = s_tvalid && s_tready;

	// Decisions for a render word, taken from current state
	logic [CNT_W-1:0] src_idx;
	logic [CNT_W-1:0] dac_idx;
	logic             published;
	logic             do_load;
	logic             do_snap;
	logic             is_render;
	logic             is_live;
	logic [CNT_W:0]   pub_sum;

	assign src_idx   = src_pos_q[POS_W-1:FRAC_BITS];
	assign dac_idx   = dac_pos_q[POS_W-1:FRAC_BITS];
	assign published = src_idx < pub_cnt_q;
	assign do_load   = published && (!src_vld_q || src_idx != last_src_q);
	assign do_snap   = !dac_vld_q || dac_idx != last_dac_q;
	assign is_render = in_action == ACT_RENDER;
	assign is_live   = is_render && dac_step_q != '0;
	assign pub_sum   = {1'b0, pub_cnt_q} + (CNT_W+1)'(SAMPLES_PER_VBLANK);

	// Ring access: write on a write word, read on a live render that loads a new source pair
	ring_req_t         ring_req;
	logic [PAIR_W-1:0] ring_rd_data;

	always_comb begin
		ring_req.wr_en   = in_acc && in_action == ACT_WRITE;
		ring_req.wr_addr = in_slot[RING_AW-1:0];
		ring_req.wr_data = {in_b, in_a};
		ring_req.rd_en   = in_acc && is_live && do_load;
		ring_req.rd_addr = src_idx[RING_AW-1:0];
	end

	gtpr_ring u_ring (
		.clk     (clk),
		.req     (ring_req),
		.rd_data (ring_rd_data)
	);

	// Positions, published count and index tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_pos_q  <= '0;
			dac_pos_q  <= '0;
			pub_cnt_q  <= '0;
			last_src_q <= '0;
			last_dac_q <= '0;
			src_vld_q  <= 1'b0;
			dac_vld_q  <= 1'b0;
		end else if (in_acc) begin
			unique case (in_action)
				ACT_PUBLISH: begin
					pub_cnt_q <= pub_sum[CNT_W] ? '1 : pub_sum[CNT_W-1:0];
				end
				ACT_RENDER: begin
					if (is_live) begin
						if (do_load) begin
							last_src_q <= src_idx;
							src_vld_q  <= 1'b1;
						end
						if (do_snap) begin
							last_dac_q <= dac_idx;
							dac_vld_q  <= 1'b1;
						end
						if (published) begin
							src_pos_q <= src_pos_q + POS_W'(src_step_q);
						end
						dac_pos_q <= dac_pos_q + POS_W'(dac_step_q);
					end
				end
				default: ;
			endcase
		end
	end

	// Render stage: waits for the ring read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			silent_s1   <= 1'b0;
			load_s1     <= 1'b0;
			snap_s1     <= 1'b0;
			underrun_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1      <= in_acc && is_render;
			silent_s1   <= !is_live;
			load_s1     <= do_load;
			snap_s1     <= do_snap;
			underrun_s1 <= !published;
		end
	end

	// Held pairs as this word leaves the render stage
	logic [PAIR_W-1:0] new_src;
	logic [PAIR_W-1:0] new_dac;

	assign new_src = load_s1 ? ring_rd_data : held_src_q;
	assign new_dac = snap_s1 ? new_src : held_dac_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_src_q <= '0;
			held_dac_q <= '0;
		end else if (advance && !silent_s1) begin
			held_src_q <= new_src;
			held_dac_q <= new_dac;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (advance) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q  <= silent_s1 ? '0 : new_dac;
			out_under_q <= silent_s1 ? 1'b0 : underrun_s1;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_under_q;

	// Checks
	`GTPR_ASSERT(a_stall_blocks_input, (vld_s1 && out_vld_q && !m_tready) |-> !s_tready)
	`GTPR_ASSERT_NEXT(a_silent_is_zero, advance && silent_s1, m_tdata == '0 && m_tuser == 1'b0)
	`GTPR_ASSERT_NEXT(a_pub_monotonic, 1'b1, pub_cnt_q >= $past(pub_cnt_q))
	`GTPR_ASSERT_NEXT(a_src_pos_gated, !(in_acc && is_live), $stable(src_pos_q) && $stable(dac_pos_q))

endmodule

`default_nettype wire
